### src/task_slot_alloc_priority_ready_queue_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the task slot ready queue
// Concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ---------------------------------------------------------------------------
`ifndef TASK_SLOT_ALLOC_PRIORITY_READY_QUEUE_MACROS_SVH
`define TASK_SLOT_ALLOC_PRIORITY_READY_QUEUE_MACROS_SVH

`ifndef ASSERT_OFF
// clocked check, masked while reset is high
`define TSQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked check, active in every cycle
`define TSQ_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TSQ_ASSERT(label, clk, rst, prop, msg)
`define TSQ_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

### src/tsq_pkg.sv
// ---------------------------------------------------------------------------
// tsq_pkg
// Shared sizes, codes and record types for the task slot ready queue.
// ---------------------------------------------------------------------------
package tsq_pkg;

   localparam int TASK_SLOTS   = 16;
   localparam int SLOT_W       = $clog2(TASK_SLOTS);
   localparam int CNT_W        = $clog2(TASK_SLOTS + 1);

   localparam int ADDR_W       = 32;
   localparam int WORDS_W      = 16;
   localparam int PRIO_W       = 8;
   localparam int STATUS_W     = 2;
   localparam int SLOT_FIELD_W = 4;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_CREATED = 2'd0,
      STATUS_BAD     = 2'd1,
      STATUS_FULL    = 2'd2
   } status_type;

   typedef struct packed {
      logic [PRIO_W-1:0]  prio;
      logic [SLOT_W-1:0]  slot;
      logic [ADDR_W-1:0]  entry;
      logic [ADDR_W-1:0]  stack_base;
      logic [WORDS_W-1:0] stack_words;
   } task_rec_type;

   // item moving down the chain
   typedef struct packed {
      logic         valid;
      task_rec_type rec;
   } tok_type;

   // ready list head as seen from cell 0
   typedef struct packed {
      logic         valid;
      task_rec_type rec;
   } head_type;

   // chain status back to the controller
   typedef struct packed {
      logic busy;
      logic placed;
   } chain_stat_type;

   function automatic logic [SLOT_FIELD_W-1:0] slot_field(input logic [SLOT_W-1:0] s);
      logic [SLOT_W+SLOT_FIELD_W-1:0] wide;
      wide = {{SLOT_FIELD_W{1'b0}}, s};
      return wide[SLOT_FIELD_W-1:0];
   endfunction

endpackage

### src/tsq_req_if.sv
// ---------------------------------------------------------------------------
// tsq_req_if
// Task creation request channel: valid/ready with the request payload.
// ---------------------------------------------------------------------------
interface tsq_req_if;
   logic                         valid;
   logic                         ready;
   logic [tsq_pkg::ADDR_W-1:0]   entry_address;
   logic [tsq_pkg::ADDR_W-1:0]   stack_base;
   logic [tsq_pkg::WORDS_W-1:0]  stack_words;
   logic [tsq_pkg::PRIO_W-1:0]   priority_req;

   modport source (output valid, entry_address, stack_base, stack_words, priority_req,
                   input ready);
   modport sink   (input valid, entry_address, stack_base, stack_words, priority_req,
                   output ready);
endinterface

### src/tsq_rsp_if.sv
// ---------------------------------------------------------------------------
// tsq_rsp_if
// Result channel: status, granted slot and the ready list head.
// ---------------------------------------------------------------------------
interface tsq_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [tsq_pkg::STATUS_W-1:0]      status;
   logic [tsq_pkg::SLOT_FIELD_W-1:0]  slot;
   logic                              head_valid;
   logic [tsq_pkg::SLOT_FIELD_W-1:0]  head_slot;
   logic [tsq_pkg::PRIO_W-1:0]        head_priority;
   logic [tsq_pkg::ADDR_W-1:0]        head_entry;

   modport source (output valid, status, slot, head_valid, head_slot, head_priority,
                   head_entry, input ready);
   modport sink   (input valid, status, slot, head_valid, head_slot, head_priority,
                   head_entry, output ready);
endinterface

### src/tsq_cell.sv
// ---------------------------------------------------------------------------
// tsq_cell
// One ready list position. Keeps a task record; the travelling item either
// settles here, swaps with the held task, or moves on to the next cell.
// ---------------------------------------------------------------------------
module tsq_cell (
   input  logic              clock,
   input  logic              reset,
   input  tsq_pkg::tok_type  tok_i,
   output tsq_pkg::tok_type  tok_o,
   output tsq_pkg::head_type held_o,
   output logic              placed_o
);
   import tsq_pkg::*;

   logic         valid_ff, valid_in;
   task_rec_type rec_ff, rec_in;
   logic         tok_valid_ff;
   task_rec_type tok_rec_ff;
   tok_type      tok_in;
   logic         take;

   always_comb begin
      valid_in = valid_ff;
      rec_in   = rec_ff;
      tok_in   = '0;
      take     = 1'b0;
      if (tok_i.valid) begin
         if (!valid_ff) begin
            valid_in = 1'b1;
            rec_in   = tok_i.rec;
            take     = 1'b1;
         end else if ((rec_ff.prio < tok_i.rec.prio) ||
                      ((rec_ff.prio == tok_i.rec.prio) && (tok_i.rec.slot < rec_ff.slot))) begin
            // higher priority, or an older task of equal priority being pushed
            // down, displaces the held task; slots are handed out in creation order
            rec_in       = tok_i.rec;
            tok_in.valid = 1'b1;
            tok_in.rec   = rec_ff;
         end else begin
            tok_in = tok_i;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         tok_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         tok_valid_ff <= tok_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff     <= rec_in;
      tok_rec_ff <= tok_in.rec;
   end

   assign tok_o    = {tok_valid_ff, tok_rec_ff};
   assign held_o   = {valid_ff, rec_ff};
   assign placed_o = take;

endmodule

### src/tsq_chain.sv
// ---------------------------------------------------------------------------
// tsq_chain
// Row of list cells in priority order; cell 0 is the list head.
// ---------------------------------------------------------------------------
module tsq_chain (
   input  logic                    clock,
   input  logic                    reset,
   input  tsq_pkg::tok_type        tok_i,
   output tsq_pkg::head_type       head_o,
   output tsq_pkg::chain_stat_type stat_o
);
   import tsq_pkg::*;

   tok_type              link [TASK_SLOTS+1];
   head_type             held [TASK_SLOTS];
   logic [TASK_SLOTS-1:0] placed;
   logic                  busy;

   assign link[0] = tok_i;

   for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_cell
      tsq_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .tok_i    (link[i]),
         .tok_o    (link[i+1]),
         .held_o   (held[i]),
         .placed_o (placed[i])
      );
   end

   always_comb begin
      busy = tok_i.valid;
      for (int i = 1; i <= TASK_SLOTS; i++) begin
         busy = busy | link[i].valid;
      end
   end

   assign head_o = held[0];
   assign stat_o = {busy, |placed};

endmodule

### src/task_slot_alloc_priority_ready_queue.sv
// ---------------------------------------------------------------------------
// task_slot_alloc_priority_ready_queue
// Task slot allocator feeding a priority ordered ready list.
// ---------------------------------------------------------------------------
// Usage: req_ch carries one task creation request per item (entry address,
// stack base, stack words, priority). rsp_ch returns exactly one item per
// request: status, granted slot and the current head of the ready list.
// A request with a zero address, base or size returns bad parameter; with
// every slot taken it returns no free slot. Slots are handed out in order
// and never freed.
// Timing: one request is in work at a time. A rejected or refused request
// shows its result from the reply state once the output register is free.
// A created task enters the chain at the head and moves one cell per cycle
// until it settles behind every task of equal or higher priority; the
// request side is ready again in the cycle the result is loaded.
// Reset empties the list and the slot count.
// A stalled result sits in the output register; the next request is still
// taken and processed, and its result waits until the register drains.
// ---------------------------------------------------------------------------
`include "task_slot_alloc_priority_ready_queue_macros.svh"

module task_slot_alloc_priority_ready_queue (
   input logic       clock,
   input logic       reset,
   tsq_req_if.sink   req_ch,
   tsq_rsp_if.source rsp_ch
);
   import tsq_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_REPLY
   } state_type;

   state_type              state_ff;
   logic [CNT_W-1:0]       used_ff;
   logic                   inject_valid_ff;
   task_rec_type           inject_rec_ff;
   tok_type                inject;
   status_type             status_ff;
   logic [SLOT_W-1:0]      slot_ff;

   logic                   rsp_valid_ff;
   status_type             rsp_status_ff;
   logic [SLOT_FIELD_W-1:0] rsp_slot_ff;
   logic                   rsp_head_valid_ff;
   logic [SLOT_FIELD_W-1:0] rsp_head_slot_ff;
   logic [PRIO_W-1:0]      rsp_head_prio_ff;
   logic [ADDR_W-1:0]      rsp_head_entry_ff;

   head_type               head;
   chain_stat_type         chain_stat;
   logic                   req_take;
   logic                   bad_req;
   logic                   full;
   logic                   out_free;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;
   assign bad_req      = (req_ch.entry_address == '0) || (req_ch.stack_base == '0) ||
                         (req_ch.stack_words == '0);
   assign full         = (used_ff == CNT_W'(TASK_SLOTS));
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign inject       = {inject_valid_ff, inject_rec_ff};

   tsq_chain u_chain (
      .clock  (clock),
      .reset  (reset),
      .tok_i  (inject),
      .head_o (head),
      .stat_o (chain_stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         used_ff         <= '0;
         inject_valid_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         // the reply state reloads the output register itself
         if (rsp_valid_ff && rsp_ch.ready && state_ff != ST_REPLY) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  if (bad_req) begin
                     status_ff <= STATUS_BAD;
                     state_ff  <= ST_REPLY;
                  end else if (full) begin
                     status_ff <= STATUS_FULL;
                     state_ff  <= ST_REPLY;
                  end else begin
                     status_ff       <= STATUS_CREATED;
                     used_ff         <= used_ff + CNT_W'(1);
                     inject_valid_ff <= 1'b1;
                     state_ff        <= ST_WALK;
                  end
               end
            end
            ST_WALK: begin
               inject_valid_ff <= 1'b0;
               if (chain_stat.placed) begin
                  state_ff <= ST_REPLY;
               end
            end
            ST_REPLY: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_take) begin
         slot_ff                   <= bad_req ? '0 : used_ff[SLOT_W-1:0];
         inject_rec_ff.prio        <= req_ch.priority_req;
         inject_rec_ff.slot        <= used_ff[SLOT_W-1:0];
         inject_rec_ff.entry       <= req_ch.entry_address;
         inject_rec_ff.stack_base  <= req_ch.stack_base;
         inject_rec_ff.stack_words <= req_ch.stack_words;
      end
      if (state_ff == ST_REPLY && out_free) begin
         rsp_status_ff     <= status_ff;
         rsp_slot_ff       <= (status_ff == STATUS_CREATED) ? slot_field(slot_ff) : '0;
         rsp_head_valid_ff <= head.valid;
         rsp_head_slot_ff  <= head.valid ? slot_field(head.rec.slot) : '0;
         rsp_head_prio_ff  <= head.valid ? head.rec.prio : '0;
         rsp_head_entry_ff <= head.valid ? head.rec.entry : '0;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = rsp_status_ff;
   assign rsp_ch.slot          = rsp_slot_ff;
   assign rsp_ch.head_valid    = rsp_head_valid_ff;
   assign rsp_ch.head_slot     = rsp_head_slot_ff;
   assign rsp_ch.head_priority = rsp_head_prio_ff;
   assign rsp_ch.head_entry    = rsp_head_entry_ff;

   `TSQ_ASSERT(a_count_bound, clock, reset, used_ff <= CNT_W'(TASK_SLOTS), "slot count overflow")
   `TSQ_ASSERT(a_idle_chain_quiet, clock, reset, state_ff == ST_IDLE |-> !chain_stat.busy, "item in chain while idle")
   `TSQ_ASSERT(a_place_in_walk, clock, reset, chain_stat.placed |-> state_ff == ST_WALK, "item settled outside walk")
   `TSQ_ASSERT(a_created_has_head, clock, reset, rsp_valid_ff && rsp_status_ff == STATUS_CREATED |-> rsp_head_valid_ff, "created task but list empty")

endmodule
